// ===== hdl/deqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_pkg
// Shared types, codes and widths of the double-ended queue with search.
// ----------------------------------------------------------------------------
package deqs_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam int FUNC_W = 3;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_SEARCH     = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} ring_req_t;

endpackage

// ===== hdl/deqs_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_req_if
// Request channel: operation code and operand value.
// ----------------------------------------------------------------------------
interface deqs_req_if;
	logic                                valid;
	logic                                ready;
	logic [deqs_pkg::FUNC_W-1:0]         func;
	logic signed [deqs_pkg::VAL_W-1:0]   item_value;

	modport source (output valid, func, item_value, input ready);
	modport sink (input valid, func, item_value, output ready);
endinterface

// ===== hdl/deqs_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_rsp_if
// Response channel: status, popped value, search result and entry count.
// ----------------------------------------------------------------------------
interface deqs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [deqs_pkg::STAT_W-1:0]         status;
	logic signed [deqs_pkg::VAL_W-1:0]   removed_value;
	logic                                found;
	logic [deqs_pkg::POS_W-1:0]          match_position;
	logic [deqs_pkg::CNT_W-1:0]          entry_count;

	modport source (output valid, status, removed_value, found, match_position,
		entry_count, input ready);
	modport sink (input valid, status, removed_value, found, match_position,
		entry_count, output ready);
endinterface

// ===== hdl/double_ended_queue_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded double-ended queue of signed words with a front-first search.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request beat: func (push front, push back, pop front,
//   pop back, search) and item_value. rsp returns exactly one beat per
//   request with status, removed_value, found, match_position, entry_count.
//   The block takes one request at a time; req.ready is high only while
//   the sequencer is idle.
//   Pushes, unused codes and requests on an empty store go through the
//   execute and response steps; pops add a read step between them, and a
//   search scans the entries (one store read and one compare per cycle,
//   front first, stopping at the first match).
//   A full response register sits on rsp; a stalled receiver holds the
//   beat there while the next request is worked on, and that one waits
//   in its last step until the register frees.
//   Reset empties the queue at once (front index and count cleared);
//   the slots are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
	parameter int DEPTH     = deqs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = deqs_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	deqs_req_if.sink      req,
	deqs_rsp_if.source    rsp
);
	import deqs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t               state_q, state_d;
	logic [FUNC_W-1:0]    func_q;
	logic [WORD_BITS-1:0] key_q;
	logic [AW-1:0]        front_q, front_d;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        pos_q, pos_d;
	logic                 inflight_s1, inflight_d;
	logic [AW-1:0]        pos_s1, pos_s1_d;

	status_t              res_status_q, res_status_d;
	logic [VAL_W-1:0]     res_removed_q, res_removed_d;
	logic                 res_found_q, res_found_d;
	logic [AW-1:0]        res_pos_q, res_pos_d;

	logic                 out_valid_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [VAL_W-1:0]     out_removed_q;
	logic                 out_found_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [CNT_W-1:0]     out_count_q;

	ring_req_t                   ring_req;
	logic [AW-1:0]               ring_offset;
	logic [AW-1:0]               ring_addr;
	logic [WORD_BITS-1:0]        ring_rdata;
	logic signed [WORD_BITS-1:0] rdata_signed;
	logic                        accept;
	logic                        out_free;
	logic                        out_load;
	logic                        full;
	logic                        empty;
	logic                        hit;

	deqs_ring #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ring (
		.clk    (clk),
		.req    (ring_req),
		.front  (front_q),
		.offset (ring_offset),
		.wdata  (key_q),
		.addr   (ring_addr),
		.rdata  (ring_rdata)
	);

	assign accept       = req.valid && req.ready;
	assign req.ready    = (state_q == S_IDLE);
	assign out_free     = !out_valid_q || rsp.ready;
	assign full         = (count_q == CW'(DEPTH));
	assign empty        = (count_q == '0);
	assign rdata_signed = $signed(ring_rdata);
	assign hit          = inflight_s1 && (ring_rdata == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		front_d       = front_q;
		count_d       = count_q;
		pos_d         = pos_q;
		inflight_d    = 1'b0;
		pos_s1_d      = pos_s1;
		res_status_d  = res_status_q;
		res_removed_d = res_removed_q;
		res_found_d   = res_found_q;
		res_pos_d     = res_pos_q;
		ring_req      = '0;
		ring_offset   = '0;
		out_load      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d       = S_EXEC;
					res_status_d  = STAT_DONE;
					res_removed_d = '0;
					res_found_d   = 1'b0;
					res_pos_d     = '0;
					pos_d         = '0;
				end
			end
			S_EXEC: begin
				unique case (func_q)
					FN_PUSH_FRONT: begin
						state_d = S_RESP;
						if (full) begin
							res_status_d = STAT_FULL;
						end else begin
							ring_offset = AW'(DEPTH - 1);
							ring_req.wr = 1'b1;
							front_d     = ring_addr;
							count_d     = count_q + 1'b1;
						end
					end
					FN_PUSH_BACK: begin
						state_d = S_RESP;
						if (full) begin
							res_status_d = STAT_FULL;
						end else begin
							ring_offset = AW'(count_q);
							ring_req.wr = 1'b1;
							count_d     = count_q + 1'b1;
						end
					end
					FN_POP_FRONT, FN_POP_BACK: begin
						if (empty) begin
							res_status_d = STAT_EMPTY;
							state_d      = S_RESP;
						end else begin
							ring_offset = (func_q == FN_POP_BACK) ?
								AW'(count_q - 1'b1) : '0;
							ring_req.rd = 1'b1;
							state_d     = S_POP;
						end
					end
					FN_SEARCH: begin
						if (empty) begin
							res_status_d = STAT_EMPTY;
							state_d      = S_RESP;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_POP: begin
				res_removed_d = VAL_W'(rdata_signed);
				count_d       = count_q - 1'b1;
				if (func_q == FN_POP_FRONT) begin
					ring_offset = AW'(1);
					front_d     = ring_addr;
				end
				state_d = S_RESP;
			end
			S_SCAN: begin
				priority if (hit) begin
					res_found_d = 1'b1;
					res_pos_d   = pos_s1;
					state_d     = S_RESP;
				end else if (pos_q < count_q) begin
					ring_offset = AW'(pos_q);
					ring_req.rd = 1'b1;
					inflight_d  = 1'b1;
					pos_s1_d    = AW'(pos_q);
					pos_d       = pos_q + 1'b1;
				end else if (!inflight_s1) begin
					state_d = S_RESP;
				end else begin
					// last read still in flight
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			inflight_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			front_q     <= front_d;
			count_q     <= count_d;
			pos_q       <= pos_d;
			inflight_s1 <= inflight_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q  <= WORD_BITS'($unsigned(req.item_value));
		end
		pos_s1        <= pos_s1_d;
		res_status_q  <= res_status_d;
		res_removed_q <= res_removed_d;
		res_found_q   <= res_found_d;
		res_pos_q     <= res_pos_d;
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_removed_q;
			out_found_q   <= res_found_q;
			out_pos_q     <= POS_W'(res_pos_q);
			out_count_q   <= CNT_W'(count_q);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.removed_value  = $signed(out_removed_q);
	assign rsp.found          = out_found_q;
	assign rsp.match_position = out_pos_q;
	assign rsp.entry_count    = out_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> pos_q <= count_q)
		else $error("scan position past live entries");

	a_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ring_req.wr |-> state_q == S_EXEC && !ring_req.rd)
		else $error("store write outside execute step");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_EMPTY |-> rsp.entry_count == '0)
		else $error("empty status with nonzero count");
`endif

endmodule

// ===== hdl/deqs_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_ring
// Circular word store with one shared wrap adder for slot addressing.
// ----------------------------------------------------------------------------
module deqs_ring #(
	parameter int DEPTH     = deqs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = deqs_pkg::WORD_BITS_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  deqs_pkg::ring_req_t   req,
	input  logic [AW-1:0]         front,
	input  logic [AW-1:0]         offset,
	input  logic [WORD_BITS-1:0]  wdata,
	output logic [AW-1:0]         addr,
	output logic [WORD_BITS-1:0]  rdata
);
	import deqs_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [AW:0]          sum;
	logic [WORD_BITS-1:0] rdata_q;

	// front + offset, folded once into the ring
	always_comb begin
		sum = {1'b0, front} + {1'b0, offset};
		if (sum >= (AW+1)'(DEPTH)) begin
			addr = AW'(sum - (AW+1)'(DEPTH));
		end else begin
			addr = sum[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sim/double_ended_queue_with_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_test
// Self-checking bench for the double-ended queue with search. A short table
// of directed requests covers the empty and full store, the word extremes,
// the back entry in a search and the spare codes. Random traffic follows,
// biased so that the store swings between empty and full. A shadow copy of
// the queue predicts every response beat that the table leaves open. The idle
// and stall mix changes from phase to phase, and one long receiver hold-off
// backs up the request side.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_test;
	import deqs_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int PHASE_ITEMS  = 118;
	localparam int HUSH_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 300000;

	localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  removed;
		logic              found;
		logic [POS_W-1:0]  pos;
		logic [CNT_W-1:0]  count;
	} deq_beat_t;

	typedef struct {
		logic [FUNC_W-1:0] f;
		logic [VAL_W-1:0]  v;
		int                reps;
		bit                known;
		deq_beat_t         beat;
	} stim_row_t;

	typedef struct {
		bit        known;
		deq_beat_t beat;
	} row_due_t;

	logic clk = 1'b0;
	logic arst_n;

	deqs_req_if req();
	deqs_rsp_if rsp();

	double_ended_queue_with_search dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// shadow of the queue
	logic [VAL_W-1:0] ring [DEPTH];
	logic [POS_W-1:0] ring_head = '0;
	logic [CNT_W-1:0] ring_fill = '0;

	row_due_t  typed_due [$];
	deq_beat_t beats_due [$];

	int errors = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hush_asked = 0;
	int hush_served = 0;
	int hush_left = 0;
	int shadow_fill = 0;
	int n_beats = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_hits = 0;
	int n_removed = 0;

	stim_row_t plan [27] = '{
		'{FN_POP_FRONT,  32'h0,        1,  1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 4'd0, 5'd0}},
		'{FN_POP_BACK,   32'h0,        1,  1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 4'd0, 5'd0}},
		'{FN_SEARCH,     32'h5,        1,  1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 4'd0, 5'd0}},
		'{FN_SPARE_LO,   32'hffffffff, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd0}},
		'{FN_PUSH_BACK,  32'h7fffffff, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd1}},
		'{FN_PUSH_FRONT, 32'h80000000, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd2}},
		'{FN_SEARCH,     32'h7fffffff, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b1, 4'd1, 5'd2}},
		'{FN_SEARCH,     32'h0,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd2}},
		'{FN_POP_BACK,   32'h0,        1,  1'b1,
			'{STAT_DONE, 32'h7fffffff, 1'b0, 4'd0, 5'd1}},
		'{FN_POP_FRONT,  32'hffffffff, 1,  1'b1,
			'{STAT_DONE, 32'h80000000, 1'b0, 4'd0, 5'd0}},
		'{FN_PUSH_BACK,  32'h0,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd1}},
		'{FN_POP_FRONT,  32'h0,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd0}},
		'{FN_PUSH_BACK,  32'hffffffff, 15, 1'b0, '0},
		'{FN_PUSH_FRONT, 32'h1,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd16}},
		'{FN_PUSH_BACK,  32'h5,        1,  1'b1, '{STAT_FULL,  32'h0, 1'b0, 4'd0, 5'd16}},
		'{FN_PUSH_FRONT, 32'h5,        1,  1'b1, '{STAT_FULL,  32'h0, 1'b0, 4'd0, 5'd16}},
		'{FN_SEARCH,     32'h1,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b1, 4'd0, 5'd16}},
		'{FN_SEARCH,     32'hffffffff, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b1, 4'd1, 5'd16}},
		'{FN_SPARE_MID,  32'h0,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd16}},
		'{FN_SPARE_HI,   32'h0,        1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd16}},
		'{FN_POP_FRONT,  32'h0,        1,  1'b1, '{STAT_DONE,  32'h1, 1'b0, 4'd0, 5'd15}},
		'{FN_PUSH_BACK,  32'h12345678, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 4'd0, 5'd16}},
		'{FN_SEARCH,     32'h12345678, 1,  1'b1, '{STAT_DONE,  32'h0, 1'b1, 4'd15, 5'd16}},
		'{FN_POP_FRONT,  32'h0,        3,  1'b0, '0},
		'{FN_PUSH_FRONT, 32'h55aa55aa, 2,  1'b0, '0},
		'{FN_POP_BACK,   32'h0,        15, 1'b0, '0},
		'{FN_POP_BACK,   32'h0,        1,  1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 4'd0, 5'd0}}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("double_ended_queue_with_search test failed");
			$finish;
		end
	end

	function automatic deq_beat_t apply_request(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v);
		deq_beat_t        b;
		logic [POS_W-1:0] at;
		logic [CNT_W-1:0] last;
		b = '0;
		b.status = STAT_DONE;
		case (f)
			FN_PUSH_FRONT: begin
				if (ring_fill == DEPTH) begin
					b.status = STAT_FULL;
				end else begin
					ring_head = ring_head - 1'b1;
					ring[ring_head] = v;
					ring_fill = ring_fill + 1'b1;
				end
			end
			FN_PUSH_BACK: begin
				if (ring_fill == DEPTH) begin
					b.status = STAT_FULL;
				end else begin
					at = ring_head + ring_fill[POS_W-1:0];
					ring[at] = v;
					ring_fill = ring_fill + 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (ring_fill == 0) begin
					b.status = STAT_EMPTY;
				end else begin
					b.removed = ring[ring_head];
					ring_head = ring_head + 1'b1;
					ring_fill = ring_fill - 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (ring_fill == 0) begin
					b.status = STAT_EMPTY;
				end else begin
					last = ring_fill - 1'b1;
					at = ring_head + last[POS_W-1:0];
					b.removed = ring[at];
					ring_fill = ring_fill - 1'b1;
				end
			end
			FN_SEARCH: begin
				if (ring_fill == 0) begin
					b.status = STAT_EMPTY;
				end else begin
					for (int i = 0; i < ring_fill; i++) begin
						at = ring_head + i[POS_W-1:0];
						if (!b.found && ring[at] == v) begin
							b.found = 1'b1;
							b.pos = i[POS_W-1:0];
						end
					end
				end
			end
			default: ;
		endcase
		b.count = ring_fill;
		return b;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hush_asked != hush_served) begin
				hush_served = hush_asked;
				hush_left = HUSH_CYCLES;
				rsp.ready <= 1'b0;
			end else if (hush_left != 0) begin
				hush_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		row_due_t  d;
		deq_beat_t want;
		deq_beat_t got;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				d = typed_due.pop_front();
				want = apply_request(req.func, req.item_value);
				n_beats++;
				if (want.status == STAT_FULL) n_full++;
				if (want.status == STAT_EMPTY) n_empty++;
				if (want.found) n_hits++;
				if (want.status == STAT_DONE && (req.func == FN_POP_FRONT ||
						req.func == FN_POP_BACK)) n_removed++;
				beats_due.push_back(d.known ? d.beat : want);
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.removed_value, rsp.found, rsp.match_position,
					rsp.entry_count};
				if (beats_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected response beat, expected none got %h",
						$time, got);
				end else begin
					want = beats_due.pop_front();
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d got %0d",
							$time, want.status, got.status);
					end
					if (got.removed !== want.removed) begin
						errors++;
						$display("%0t: removed_value expected %h got %h",
							$time, want.removed, got.removed);
					end
					if (got.found !== want.found) begin
						errors++;
						$display("%0t: found expected %0d got %0d",
							$time, want.found, got.found);
					end
					if (got.pos !== want.pos) begin
						errors++;
						$display("%0t: match_position expected %0d got %0d",
							$time, want.pos, got.pos);
					end
					if (got.count !== want.count) begin
						errors++;
						$display("%0t: entry_count expected %0d got %0d",
							$time, want.count, got.count);
					end
				end
			end
		end
	end

	task automatic offer(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v,
			input bit known, input deq_beat_t beat);
		row_due_t d;
		while ($urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		d.known = known;
		d.beat = beat;
		typed_due.push_back(d);
		case (f)
			FN_PUSH_FRONT, FN_PUSH_BACK: if (shadow_fill < DEPTH) shadow_fill++;
			FN_POP_FRONT, FN_POP_BACK: if (shadow_fill > 0) shadow_fill--;
			default: ;
		endcase
		req.valid <= 1'b1;
		req.func <= f;
		req.item_value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	initial begin
		logic [VAL_W-1:0]  pool [8];
		logic [FUNC_W-1:0] f;
		logic [VAL_W-1:0]  v;
		bit                tide;
		bit                spare;
		bit                hush_done;
		int                n;
		int                r;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = '0;
		req.item_value = '0;
		pool = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h1, 32'hffffffff,
			32'h2a, 32'hdeadbeef, 32'h00ff00ff};
		tide = 1'b1;
		hush_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps) offer(plan[i].f, plan[i].v, plan[i].known, plan[i].beat);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (shadow_fill == DEPTH && $urandom_range(0, 3) == 0) tide = 1'b0;
				if (shadow_fill == 0 && $urandom_range(0, 3) == 0) tide = 1'b1;
				r = $urandom_range(0, 99);
				spare = 1'b0;
				v = $urandom;
				if (r < 4) begin
					f = FN_SPARE_LO + FUNC_W'($urandom_range(0, 2));
					spare = 1'b1;
				end else if (r < 28) begin
					f = FN_SEARCH;
					if ($urandom_range(0, 99) < 65) v = pool[$urandom_range(0, 7)];
				end else if ($urandom_range(0, 99) < (tide ? 72 : 28)) begin
					f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
					if ($urandom_range(0, 9) < 4) v = pool[$urandom_range(0, 7)];
					else pool[$urandom_range(2, 7)] = v;
				end else begin
					f = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
				end
				offer(f, v, 1'b0, '0);
				if (!spare) n++;
				if (phase == 2 && n == 20 && !hush_done) begin
					hush_done = 1'b1;
					hush_asked++;
				end
			end
			// sender rests until the queue of responses runs dry
			req.valid <= 1'b0;
			while (typed_due.size() != 0 || beats_due.size() != 0) @(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests over four idle/stall mixes: %0d pops returned data,",
			n_beats, n_removed);
		$display("%0d pushes hit a full store, %0d requests an empty one, %0d search hits",
			n_full, n_empty, n_hits);
		if (errors == 0) begin
			$display("double_ended_queue_with_search test passed");
		end else begin
			$display("double_ended_queue_with_search test failed");
		end
		$finish;
	end

endmodule
